// ----- rtl/core/usbpr_pkg.sv -----
// usbpr_pkg: shared constants for the USB port route and power controller.
// Holds function codes, route and wifi command codes, register map and reset values.
// No dependencies.
`default_nettype none

package usbpr_pkg;

    localparam int DEBOUNCE_LIMIT = 4;
    localparam int TIMER_BITS     = 16;
    localparam int CNT_BITS       = 3;
    localparam int PADDR_BITS     = 5;

    // item function codes
    localparam logic [1:0] FUNC_POLL   = 2'd0;
    localparam logic [1:0] FUNC_WAKE   = 2'd1;
    localparam logic [1:0] FUNC_RESYNC = 2'd2;

    // mux route codes
    localparam logic [1:0] ROUTE_OFF    = 2'd0;
    localparam logic [1:0] ROUTE_LOCAL  = 2'd1;
    localparam logic [1:0] ROUTE_LAPTOP = 2'd2;

    // route override codes
    localparam logic [1:0] OVR_AUTO   = 2'd0;
    localparam logic [1:0] OVR_LAPTOP = 2'd1;

    // wifi commands
    localparam logic [1:0] WIFI_NONE  = 2'd0;
    localparam logic [1:0] WIFI_STOP  = 2'd1;
    localparam logic [1:0] WIFI_START = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_WIFI_OFF    = 3'd0;
    localparam logic [2:0] REG_UNPLUG_WIFI = 3'd1;
    localparam logic [2:0] REG_SLEEP_EN    = 3'd2;
    localparam logic [2:0] REG_ROUTE_OVR   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT     = 3'd4;

    localparam logic [TIMER_BITS-1:0] TIMEOUT_RESET = TIMER_BITS'(6000);
    localparam logic [TIMER_BITS-1:0] IDLE_MAX      = {TIMER_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]   DEB_MAX       = CNT_BITS'(DEBOUNCE_LIMIT);

endpackage

`default_nettype wire

// ----- rtl/core/usb_port_route_power_controller.sv -----
// usb_port_route_power_controller: VBUS debounce, mux routing, rail and idle sleep control.
// Depends on usbpr_pkg.
//
// Usage:
//   Input channel s_* carries one item: a poll tick, a manual wake or a resync,
//   plus the raw VBUS level and the wifi link busy flag. Result channel m_*
//   carries one beat per item: rail enable, mux route, wifi command, debounced
//   presence, sleep flag and idle ticks remaining.
//   The result of a beat is registered at the edge that accepts the beat.
//   Throughput is one item per cycle while the receiver takes results; the
//   whole update is one pass of flag and counter logic ahead of the result register.
//   s_ready is high while the result register is empty or being taken, so a
//   stalled receiver holds one result and stalls the input after that.
//   Reset (aresetn low, synchronous) clears all port state to rail off, route
//   disconnected, no presence, awake, and restores register defaults.
//   The user must write settings over the APB port only while idle; the block
//   itself does not enforce this. Writes never wake a sleeping port.
`default_nettype none

module usb_port_route_power_controller (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [usbpr_pkg::PADDR_BITS-1:0]  paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    // input items
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_func,
    input  wire logic                              s_vbus_level,
    input  wire logic                              s_link_busy,
    // results
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_rail_enable,
    output logic      [1:0]                        m_mux_route,
    output logic      [1:0]                        m_wifi_command,
    output logic                                   m_usbc_present,
    output logic                                   m_sleeping,
    output logic      [usbpr_pkg::TIMER_BITS-1:0]  m_idle_remaining
);
    import usbpr_pkg::*;

    // configuration registers
    logic                  wifi_off_reg;
    logic                  unplug_wifi_reg;
    logic                  sleep_en_reg;
    logic [1:0]            route_ovr_reg;
    logic [TIMER_BITS-1:0] timeout_reg;

    // port state
    logic [CNT_BITS-1:0]   vbus_cnt_reg,  vbus_cnt_next;
    logic                  seen_reg,      seen_next;
    logic                  asleep_reg,    asleep_next;
    logic [TIMER_BITS-1:0] idle_reg,      idle_next;
    logic                  rail_reg,      rail_next;
    logic [1:0]            route_reg,     route_next;
    logic [1:0]            cmd_next;
    logic [TIMER_BITS-1:0] remain_next;

    logic                  cfg_wr;
    logic [2:0]            cfg_idx;
    logic                  s_fire;
    logic [TIMER_BITS-1:0] tmo;
    logic                  usbc;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign s_ready = !m_valid || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign tmo     = (timeout_reg == '0) ? TIMER_BITS'(1) : timeout_reg;

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_WIFI_OFF:    prdata[0]   = wifi_off_reg;
            REG_UNPLUG_WIFI: prdata[0]   = unplug_wifi_reg;
            REG_SLEEP_EN:    prdata[0]   = sleep_en_reg;
            REG_ROUTE_OVR:   prdata[1:0] = route_ovr_reg;
            REG_TIMEOUT:     prdata[TIMER_BITS-1:0] = timeout_reg;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wifi_off_reg    <= 1'b0;
            unplug_wifi_reg <= 1'b0;
            sleep_en_reg    <= 1'b1;
            route_ovr_reg   <= OVR_AUTO;
            timeout_reg     <= TIMEOUT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_WIFI_OFF:    wifi_off_reg    <= pwdata[0];
                REG_UNPLUG_WIFI: unplug_wifi_reg <= pwdata[0];
                REG_SLEEP_EN:    sleep_en_reg    <= pwdata[0];
                REG_ROUTE_OVR:   route_ovr_reg   <= pwdata[1:0];
                REG_TIMEOUT:     timeout_reg     <= pwdata[TIMER_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        vbus_cnt_next = vbus_cnt_reg;
        seen_next     = seen_reg;
        asleep_next   = asleep_reg;
        idle_next     = idle_reg;
        rail_next     = rail_reg;
        route_next    = route_reg;
        cmd_next      = WIFI_NONE;
        usbc          = seen_reg;

        case (s_func)
            FUNC_POLL: begin
                if (route_ovr_reg != OVR_AUTO) begin
                    idle_next = '0;
                end else begin
                    if (idle_reg != IDLE_MAX)
                        idle_next = idle_reg + TIMER_BITS'(1);
                    if (s_vbus_level && vbus_cnt_reg < DEB_MAX)
                        vbus_cnt_next = vbus_cnt_reg + CNT_BITS'(1);
                    if (!s_vbus_level && vbus_cnt_reg != '0)
                        vbus_cnt_next = vbus_cnt_reg - CNT_BITS'(1);
                    if (vbus_cnt_next >= DEB_MAX)
                        usbc = 1'b1;
                    if (vbus_cnt_next == '0)
                        usbc = 1'b0;

                    if (usbc && !seen_reg) begin
                        asleep_next = 1'b0;
                        rail_next   = 1'b1;
                        route_next  = ROUTE_LAPTOP;
                        if (wifi_off_reg)
                            cmd_next = WIFI_STOP;
                    end else if (!usbc && seen_reg) begin
                        asleep_next = 1'b0;
                        rail_next   = 1'b1;
                        route_next  = ROUTE_LOCAL;
                        idle_next   = '0;
                        if (unplug_wifi_reg)
                            cmd_next = WIFI_START;
                    end
                    seen_next = usbc;

                    if (usbc) begin
                        idle_next = '0;
                    end else if (!asleep_next) begin
                        if (!sleep_en_reg) begin
                            idle_next = '0;
                        end else begin
                            if (s_link_busy)
                                idle_next = '0;
                            if (idle_next >= tmo) begin
                                cmd_next    = WIFI_STOP;
                                rail_next   = 1'b0;
                                route_next  = ROUTE_OFF;
                                asleep_next = 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_WAKE: begin
                asleep_next = 1'b0;
                rail_next   = 1'b1;
                route_next  = ROUTE_LOCAL;
                idle_next   = '0;
                cmd_next    = WIFI_START;
            end
            FUNC_RESYNC: begin
                asleep_next = 1'b0;
                rail_next   = 1'b1;
                idle_next   = '0;
                cmd_next    = WIFI_START;
                if (route_ovr_reg == OVR_AUTO) begin
                    vbus_cnt_next = s_vbus_level ? DEB_MAX : '0;
                    seen_next     = s_vbus_level;
                    route_next    = s_vbus_level ? ROUTE_LAPTOP : ROUTE_LOCAL;
                end else if (route_ovr_reg == OVR_LAPTOP) begin
                    route_next = ROUTE_LAPTOP;
                    cmd_next   = wifi_off_reg ? WIFI_STOP : WIFI_NONE;
                end else begin
                    route_next = ROUTE_LOCAL;
                end
            end
            default: ;
        endcase

        remain_next = '0;
        if (!asleep_next && !seen_next && sleep_en_reg && idle_next < tmo)
            remain_next = tmo - idle_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbus_cnt_reg <= '0;
            seen_reg     <= 1'b0;
            asleep_reg   <= 1'b0;
            idle_reg     <= '0;
            rail_reg     <= 1'b0;
            route_reg    <= ROUTE_OFF;
            m_valid      <= 1'b0;
        end else begin
            if (s_fire) begin
                vbus_cnt_reg <= vbus_cnt_next;
                seen_reg     <= seen_next;
                asleep_reg   <= asleep_next;
                idle_reg     <= idle_next;
                rail_reg     <= rail_next;
                route_reg    <= route_next;
                m_valid      <= 1'b1;
            end else if (m_ready) begin
                m_valid      <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_rail_enable    <= rail_next;
            m_mux_route      <= route_next;
            m_wifi_command   <= cmd_next;
            m_usbc_present   <= seen_next;
            m_sleeping       <= asleep_next;
            m_idle_remaining <= remain_next;
        end
    end

    a_sleep_powers_down: assert property (@(posedge aclk) disable iff (!aresetn)
        asleep_reg |-> (!rail_reg && route_reg == ROUTE_OFF))
        else $error("asleep with rail or route active");

    a_present_no_countdown: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_usbc_present || m_sleeping)) |-> (m_idle_remaining == '0))
        else $error("idle countdown reported while present or asleep");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (m_valid && m_rail_enable == rail_reg && m_sleeping == asleep_reg))
        else $error("result beat does not match updated state");

    a_debounce_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vbus_cnt_reg <= DEB_MAX)
        else $error("debounce counter out of range");

endmodule

`default_nettype wire

// ----- verif/tb_usb_port_route_power_controller.sv -----
// Self-checking testbench for usb_port_route_power_controller: directed and random
// poll/wake/resync beats, APB setting changes, scoreboard with an in-class predictor.
// Depends on usbpr_pkg and the usb_port_route_power_controller RTL.
module tb_usb_port_route_power_controller;
    import usbpr_pkg::*;

    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
    localparam logic [1:0] OVR_LOCAL    = 2'd2;
    localparam logic [1:0] OVR_RESERVED = 2'd3;

    typedef struct packed {
        logic                  rail;
        logic [1:0]            route;
        logic [1:0]            wifi;
        logic                  usbc;
        logic                  asleep;
        logic [TIMER_BITS-1:0] remaining;
    } port_status_t;

    class port_state_tracker;
        bit                  wifi_off;
        bit                  unplug_wifi;
        bit                  sleep_en;
        bit [1:0]            route_ovr;
        bit [TIMER_BITS-1:0] idle_limit;
        bit [CNT_BITS-1:0]   vbus_count;
        bit                  usbc_seen;
        bit                  asleep;
        bit                  rail;
        bit [1:0]            route;
        bit [TIMER_BITS-1:0] idle_ticks;
        port_status_t        status_q[$];
        int                  errors;

        function new();
            wifi_off    = 1'b0;
            unplug_wifi = 1'b0;
            sleep_en    = 1'b1;
            route_ovr   = OVR_AUTO;
            idle_limit  = TIMEOUT_RESET;
            vbus_count  = '0;
            usbc_seen   = 1'b0;
            asleep      = 1'b0;
            rail        = 1'b0;
            route       = ROUTE_OFF;
            idle_ticks  = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_WIFI_OFF:    wifi_off    = value[0];
                REG_UNPLUG_WIFI: unplug_wifi = value[0];
                REG_SLEEP_EN:    sleep_en    = value[0];
                REG_ROUTE_OVR:   route_ovr   = value[1:0];
                REG_TIMEOUT:     idle_limit  = value[TIMER_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void power_local();
            asleep     = 1'b0;
            rail       = 1'b1;
            route      = ROUTE_LOCAL;
            idle_ticks = '0;
        endfunction

        function void note_item(logic [1:0] func, logic vbus, logic busy);
            port_status_t        st;
            bit [1:0]            cmd;
            bit [TIMER_BITS-1:0] tmo;
            bit                  usbc;
            cmd = WIFI_NONE;
            tmo = (idle_limit == 0) ? TIMER_BITS'(1) : idle_limit;
            case (func)
                FUNC_POLL: begin
                    if (route_ovr != OVR_AUTO) begin
                        idle_ticks = '0;
                    end else begin
                        if (idle_ticks != IDLE_MAX) idle_ticks++;
                        if (vbus && vbus_count < DEB_MAX) vbus_count++;
                        else if (!vbus && vbus_count != 0) vbus_count--;
                        usbc = usbc_seen;
                        if (vbus_count >= DEB_MAX) usbc = 1'b1;
                        if (vbus_count == 0) usbc = 1'b0;
                        if (usbc && !usbc_seen) begin
                            asleep = 1'b0;
                            rail   = 1'b1;
                            route  = ROUTE_LAPTOP;
                            if (wifi_off) cmd = WIFI_STOP;
                        end else if (!usbc && usbc_seen) begin
                            power_local();
                            if (unplug_wifi) cmd = WIFI_START;
                        end
                        usbc_seen = usbc;
                        if (usbc) begin
                            idle_ticks = '0;
                        end else if (!asleep) begin
                            if (!sleep_en || busy) idle_ticks = '0;
                            if (sleep_en && idle_ticks >= tmo) begin
                                cmd    = WIFI_STOP;
                                rail   = 1'b0;
                                route  = ROUTE_OFF;
                                asleep = 1'b1;
                            end
                        end
                    end
                end
                FUNC_WAKE: begin
                    power_local();
                    cmd = WIFI_START;
                end
                FUNC_RESYNC: begin
                    cmd        = WIFI_START;
                    asleep     = 1'b0;
                    rail       = 1'b1;
                    idle_ticks = '0;
                    if (route_ovr == OVR_AUTO) begin
                        vbus_count = vbus ? DEB_MAX : '0;
                        usbc_seen  = vbus;
                        route      = vbus ? ROUTE_LAPTOP : ROUTE_LOCAL;
                    end else if (route_ovr == OVR_LAPTOP) begin
                        route = ROUTE_LAPTOP;
                        cmd   = wifi_off ? WIFI_STOP : WIFI_NONE;
                    end else begin
                        route = ROUTE_LOCAL;
                    end
                end
                default: ;
            endcase
            st.rail      = rail;
            st.route     = route;
            st.wifi      = cmd;
            st.usbc      = usbc_seen;
            st.asleep    = asleep;
            st.remaining = '0;
            if (!asleep && !usbc_seen && sleep_en)
                st.remaining = (idle_ticks >= tmo) ? '0 : tmo - idle_ticks;
            status_q.push_back(st);
        endfunction

        function void check_result(port_status_t got);
            port_status_t want;
            if (status_q.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result beat: rail=%0d route=%0d wifi=%0d usbc=%0d sleep=%0d idle=%0d",
                             got.rail, got.route, got.wifi, got.usbc, got.asleep, got.remaining);
                errors++;
                return;
            end
            want = status_q.pop_front();
            if (got.rail !== want.rail || got.route !== want.route || got.wifi !== want.wifi ||
                got.usbc !== want.usbc || got.asleep !== want.asleep ||
                got.remaining !== want.remaining) begin
                if (errors < 10)
                    $display("mismatch: exp rail=%0d route=%0d wifi=%0d usbc=%0d sleep=%0d idle=%0d, got rail=%0d route=%0d wifi=%0d usbc=%0d sleep=%0d idle=%0d",
                             want.rail, want.route, want.wifi, want.usbc, want.asleep,
                             want.remaining, got.rail, got.route, got.wifi, got.usbc,
                             got.asleep, got.remaining);
                errors++;
            end
        endfunction

        function int pending();
            return status_q.size();
        endfunction
    endclass

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_BITS-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_func       = FUNC_POLL;
    logic                  s_vbus_level = 1'b0;
    logic                  s_link_busy  = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic                  m_rail_enable;
    logic [1:0]            m_mux_route;
    logic [1:0]            m_wifi_command;
    logic                  m_usbc_present;
    logic                  m_sleeping;
    logic [TIMER_BITS-1:0] m_idle_remaining;

    port_state_tracker tracker;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int busy_pct       = 10;

    usb_port_route_power_controller i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_vbus_level     (s_vbus_level),
        .s_link_busy      (s_link_busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rail_enable    (m_rail_enable),
        .m_mux_route      (m_mux_route),
        .m_wifi_command   (m_wifi_command),
        .m_usbc_present   (m_usbc_present),
        .m_sleeping       (m_sleeping),
        .m_idle_remaining (m_idle_remaining)
    );

    always #1 aclk = ~aclk;

    // valid stays high after a beat; the next call either holds it or drops it
    task automatic send_item(input logic [1:0] func, input logic vbus, input logic busy);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_func       <= func;
        s_vbus_level <= vbus;
        s_link_busy  <= busy;
        do @(posedge aclk); while (!s_ready);
        tracker.note_item(func, vbus, busy);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_reg(idx, value);
        @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // VBUS held in runs so debounce completes; occasional glitches and commands
    task automatic run_traffic(input int n);
        logic       vbus;
        logic       v;
        logic       b;
        logic [1:0] func;
        int         pick;
        vbus = 1'($urandom_range(1));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(15) == 0) vbus = ~vbus;
            v = ($urandom_range(19) == 0) ? ~vbus : vbus;
            b = ($urandom_range(99) < busy_pct);
            pick = $urandom_range(39);
            func = (pick == 0) ? FUNC_WAKE : (pick == 1) ? FUNC_RESYNC :
                   (pick == 2) ? FUNC_UNKNOWN : FUNC_POLL;
            send_item(func, v, b);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result({m_rail_enable, m_mux_route, m_wifi_command,
                                  m_usbc_present, m_sleeping, m_idle_remaining});
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #1000000;
        $display("usb_port_route_power_controller regression: fail");
        $finish;
    end

    initial begin
        logic [15:0] tmo;
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // insert/remove with both wifi actions, idle sleep, wake, resync
        write_reg(REG_WIFI_OFF, 1);
        write_reg(REG_UNPLUG_WIFI, 1);
        write_reg(REG_TIMEOUT, 3);
        send_item(FUNC_POLL, 1'b0, 1'b0);
        send_item(FUNC_POLL, 1'b0, 1'b1);
        repeat (3) send_item(FUNC_POLL, 1'b0, 1'b0);
        send_item(FUNC_POLL, 1'b0, 1'b0);
        send_item(FUNC_WAKE, 1'b0, 1'b0);
        repeat (4) send_item(FUNC_POLL, 1'b1, 1'b0);
        repeat (4) send_item(FUNC_POLL, 1'b0, 1'b0);
        send_item(FUNC_UNKNOWN, 1'b1, 1'b1);
        send_item(FUNC_RESYNC, 1'b1, 1'b0);
        send_item(FUNC_RESYNC, 1'b0, 1'b1);

        // forced modes
        settle();
        write_reg(REG_ROUTE_OVR, OVR_LAPTOP);
        send_item(FUNC_POLL, 1'b1, 1'b1);
        send_item(FUNC_RESYNC, 1'b0, 1'b0);
        send_item(FUNC_WAKE, 1'b1, 1'b0);
        settle();
        write_reg(REG_ROUTE_OVR, OVR_LOCAL);
        send_item(FUNC_RESYNC, 1'b1, 1'b0);
        settle();
        write_reg(REG_ROUTE_OVR, OVR_RESERVED);
        send_item(FUNC_POLL, 1'b0, 1'b1);
        send_item(FUNC_RESYNC, 1'b0, 1'b0);

        // zero timeout, then idle sleep disabled
        settle();
        write_reg(REG_ROUTE_OVR, OVR_AUTO);
        write_reg(REG_TIMEOUT, 0);
        send_item(FUNC_POLL, 1'b0, 1'b0);
        settle();
        write_reg(REG_SLEEP_EN, 0);
        send_item(FUNC_WAKE, 1'b0, 1'b0);
        send_item(FUNC_POLL, 1'b0, 1'b0);

        for (int p = 0; p < 12; p++) begin
            settle();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            case (p)
                1:       tmo = 16'hFFFF;
                2:       tmo = 16'd0;
                3:       tmo = 16'd1;
                5:       tmo = TIMEOUT_RESET;
                default: tmo = 16'($urandom_range(2, 24));
            endcase
            busy_pct = $urandom_range(30);
            write_reg(REG_WIFI_OFF, $urandom_range(1));
            write_reg(REG_UNPLUG_WIFI, $urandom_range(1));
            write_reg(REG_SLEEP_EN, ($urandom_range(9) != 0));
            write_reg(REG_ROUTE_OVR, ($urandom_range(4) == 0) ? $urandom_range(1, 3) : OVR_AUTO);
            write_reg(REG_TIMEOUT, tmo);
            run_traffic(154);
        end

        settle();
        repeat (4) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("usb_port_route_power_controller regression: pass");
        else
            $display("usb_port_route_power_controller regression: fail");
        $finish;
    end
endmodule
